// ===== hw/rtl/rstep_pkg.sv =====
// Shared types and constants for the instruction step core.
// Holds opcode and funct codes, syscall service codes, event codes and the
// structs passed between the register file, execute logic and top level.
package rstep_pkg;

    localparam int NUM_REGS = 32;
    localparam int XLEN     = 32;
    localparam int REG_AW   = 5;

    typedef logic [XLEN-1:0]   t_word;
    typedef logic [REG_AW-1:0] t_reg_addr;

    // Primary opcodes.
    localparam logic [5:0] OP_RTYPE    = 6'd0;
    localparam logic [5:0] OP_BEQ      = 6'd4;
    localparam logic [5:0] OP_BNE      = 6'd5;
    localparam logic [5:0] OP_ADDI     = 6'd8;
    localparam logic [5:0] OP_SLTI     = 6'd10;
    localparam logic [5:0] OP_ANDI     = 6'd12;
    localparam logic [5:0] OP_ORI      = 6'd13;
    localparam logic [5:0] OP_LUI      = 6'd15;
    localparam logic [5:0] OP_SPECIAL2 = 6'd28;

    // Funct codes.
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MUL     = 6'h02;

    // Syscall service codes found in $v0.
    localparam t_word SYS_PRINT_INT  = 32'd1;
    localparam t_word SYS_EXIT       = 32'd10;
    localparam t_word SYS_PRINT_CHAR = 32'd11;

    localparam t_reg_addr REG_V0 = 5'd2;
    localparam t_reg_addr REG_A0 = 5'd4;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_PRINT_INT   = 3'd1,
        EV_PRINT_CHAR  = 3'd2,
        EV_BAD_SYSCALL = 3'd3,
        EV_INVALID     = 3'd4
    } t_event;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word v0;
        t_word a0;
    } t_reg_reads;

    typedef struct packed {
        logic      wr_en;
        t_reg_addr addr;
        t_word     data;
    } t_reg_write;

    typedef struct packed {
        t_reg_write wb;
        t_event     kind;
        t_word      value;
        logic       halt;
    } t_exec_result;

endpackage

// ===== hw/rtl/rstep_in_stage.sv =====
// Input register stage of the instruction step core.
// Captures the instruction word and pre-reduces the branch offset modulo the
// program depth with a reciprocal multiply. Depends on rstep_pkg.
module rstep_in_stage #(
    parameter int PROG_DEPTH = 1024,
    parameter int OFF_W      = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_advance,
    input  rstep_pkg::t_word       i_instr_word,
    output logic                   o_full,
    output rstep_pkg::t_word       o_instr,
    output logic [OFF_W-1:0]       o_biased,
    output logic [OFF_W-1:0]       o_quot
);

    localparam int DEPTH_LOG = $clog2(PROG_DEPTH);
    localparam int RED_SHIFT = OFF_W + DEPTH_LOG;
    localparam int RECIP_W   = OFF_W + 2;
    localparam int PROD_W    = OFF_W + RECIP_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << RED_SHIFT) + 64'(PROG_DEPTH) - 64'd1) / 64'(PROG_DEPTH);
    // Smallest multiple of the depth that lifts any 16-bit signed offset to zero or above.
    localparam int OFF_BIAS = PROG_DEPTH * ((32768 + PROG_DEPTH - 1) / PROG_DEPTH);

    logic                   r_full;
    logic                   n_full;
    rstep_pkg::t_word       r_instr;
    logic [OFF_W-1:0]       r_biased;
    logic [OFF_W-1:0]       r_quot;
    logic [OFF_W-1:0]       w_biased;
    logic [PROD_W-1:0]      w_prod;
    logic [OFF_W-1:0]       w_quot;

    // The biased offset always fits OFF_W bits, so the wrap of the add is harmless.
    assign w_biased = OFF_W'(OFF_BIAS)
                    + {{(OFF_W-16){i_instr_word[15]}}, i_instr_word[15:0]};
    assign w_prod   = PROD_W'(w_biased) * PROD_W'(RECIP[RECIP_W-1:0]);
    assign w_quot   = OFF_W'(w_prod >> RED_SHIFT);

    always_comb begin
        n_full = r_full;
        if (i_load) begin
            n_full = 1'b1;
        end else if (i_advance) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_instr  <= i_instr_word;
            r_biased <= w_biased;
            r_quot   <= w_quot;
        end
    end

    assign o_full   = r_full;
    assign o_instr  = r_instr;
    assign o_biased = r_biased;
    assign o_quot   = r_quot;

endmodule

// ===== hw/rtl/rstep_regfile.sv =====
// Architectural register file of the instruction step core: 32 x 32 bits.
// Two read ports chosen by the instruction, fixed reads of $v0 and $a0,
// one write port. Register 0 is never written. Depends on rstep_pkg.
module rstep_regfile (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rstep_pkg::t_reg_addr  i_rd_addr_a,
    input  rstep_pkg::t_reg_addr  i_rd_addr_b,
    input  rstep_pkg::t_reg_write i_wr,
    output rstep_pkg::t_reg_reads o_rd
);

    rstep_pkg::t_word r_regs [rstep_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rstep_pkg::NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (i_wr.wr_en && (i_wr.addr != '0)) begin
            r_regs[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd.a  = r_regs[i_rd_addr_a];
    assign o_rd.b  = r_regs[i_rd_addr_b];
    assign o_rd.v0 = r_regs[rstep_pkg::REG_V0];
    assign o_rd.a0 = r_regs[rstep_pkg::REG_A0];

endmodule

// ===== hw/rtl/rstep_exec.sv =====
// Execute logic of the instruction step core: decode, ALU, branch target,
// syscall handling and next program index, all combinational.
// Depends on rstep_pkg.
module rstep_exec #(
    parameter int PROG_DEPTH = 1024,
    parameter int OFF_W      = 17,
    parameter int IW         = 10
) (
    input  rstep_pkg::t_word       i_instr,
    input  logic [OFF_W-1:0]       i_biased,
    input  logic [OFF_W-1:0]       i_quot,
    input  logic [IW-1:0]          i_pc,
    input  logic                   i_halted,
    input  rstep_pkg::t_reg_reads  i_rd,
    output rstep_pkg::t_exec_result o_res,
    output logic [IW-1:0]          o_next_pc
);

    logic [5:0]            w_op;
    logic [5:0]            w_fn;
    rstep_pkg::t_reg_addr  w_rt;
    rstep_pkg::t_reg_addr  w_rd;
    logic [15:0]           w_imm;
    rstep_pkg::t_word      w_simm;
    rstep_pkg::t_word      w_zimm;
    logic [OFF_W-1:0]      w_rem;
    logic [IW-1:0]         w_off;
    logic [IW:0]           w_sum;
    logic [IW-1:0]         w_target;
    logic [IW-1:0]         w_inc;
    logic                  w_run;
    logic                  w_legal;
    logic                  w_wr_req;
    logic                  w_taken;
    logic                  w_sys;
    rstep_pkg::t_reg_addr  w_wr_addr;
    rstep_pkg::t_word      w_wr_data;

    assign w_op   = i_instr[31:26];
    assign w_rt   = i_instr[20:16];
    assign w_rd   = i_instr[15:11];
    assign w_fn   = i_instr[5:0];
    assign w_imm  = i_instr[15:0];
    assign w_simm = {{16{w_imm[15]}}, w_imm};
    assign w_zimm = {16'h0000, w_imm};
    assign w_run  = !i_halted;

    // Finish the offset reduction: remainder of the biased offset by the depth.
    assign w_rem    = i_biased - OFF_W'(i_quot * OFF_W'(PROG_DEPTH));
    assign w_off    = IW'(w_rem);
    assign w_sum    = {1'b0, i_pc} + {1'b0, w_off};
    assign w_target = (w_sum >= (IW+1)'(PROG_DEPTH))
                    ? IW'(w_sum - (IW+1)'(PROG_DEPTH)) : IW'(w_sum);
    assign w_inc    = (i_pc == IW'(PROG_DEPTH - 1)) ? '0 : i_pc + 1'b1;

    always_comb begin
        w_legal   = 1'b1;
        w_wr_req  = 1'b0;
        w_taken   = 1'b0;
        w_sys     = 1'b0;
        w_wr_addr = w_rd;
        w_wr_data = '0;
        case (w_op)
            rstep_pkg::OP_RTYPE: begin
                case (w_fn)
                    rstep_pkg::FN_ADD: begin
                        w_wr_req  = 1'b1;
                        w_wr_data = i_rd.a + i_rd.b;
                    end
                    rstep_pkg::FN_SUB: begin
                        w_wr_req  = 1'b1;
                        w_wr_data = i_rd.a - i_rd.b;
                    end
                    rstep_pkg::FN_AND: begin
                        w_wr_req  = 1'b1;
                        w_wr_data = i_rd.a & i_rd.b;
                    end
                    rstep_pkg::FN_OR: begin
                        w_wr_req  = 1'b1;
                        w_wr_data = i_rd.a | i_rd.b;
                    end
                    rstep_pkg::FN_SLT: begin
                        w_wr_req  = 1'b1;
                        w_wr_data = {31'b0, $signed(i_rd.a) < $signed(i_rd.b)};
                    end
                    rstep_pkg::FN_SYSCALL: begin
                        w_sys = 1'b1;
                    end
                    default: begin
                        w_legal = 1'b0;
                    end
                endcase
            end
            rstep_pkg::OP_SPECIAL2: begin
                if (w_fn == rstep_pkg::FN_MUL) begin
                    w_wr_req  = 1'b1;
                    w_wr_data = i_rd.a * i_rd.b;
                end else begin
                    w_legal = 1'b0;
                end
            end
            rstep_pkg::OP_BEQ: begin
                w_taken = (i_rd.a == i_rd.b);
            end
            rstep_pkg::OP_BNE: begin
                w_taken = (i_rd.a != i_rd.b);
            end
            rstep_pkg::OP_ADDI: begin
                w_wr_req  = 1'b1;
                w_wr_addr = w_rt;
                w_wr_data = i_rd.a + w_simm;
            end
            rstep_pkg::OP_SLTI: begin
                w_wr_req  = 1'b1;
                w_wr_addr = w_rt;
                w_wr_data = {31'b0, $signed(i_rd.a) < $signed(w_simm)};
            end
            rstep_pkg::OP_ANDI: begin
                w_wr_req  = 1'b1;
                w_wr_addr = w_rt;
                w_wr_data = i_rd.a & w_zimm;
            end
            rstep_pkg::OP_ORI: begin
                w_wr_req  = 1'b1;
                w_wr_addr = w_rt;
                w_wr_data = i_rd.a | w_zimm;
            end
            rstep_pkg::OP_LUI: begin
                w_wr_req  = 1'b1;
                w_wr_addr = w_rt;
                w_wr_data = {w_imm, 16'h0000};
            end
            default: begin
                w_legal = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_res.wb.wr_en = w_legal && w_run && w_wr_req;
        o_res.wb.addr  = w_wr_addr;
        o_res.wb.data  = w_wr_data;
        o_res.kind     = rstep_pkg::EV_NONE;
        o_res.value    = '0;
        o_res.halt     = i_halted;
        if (!w_legal) begin
            o_res.kind = rstep_pkg::EV_INVALID;
        end else if (w_sys && w_run) begin
            if (i_rd.v0 == rstep_pkg::SYS_PRINT_INT) begin
                o_res.kind  = rstep_pkg::EV_PRINT_INT;
                o_res.value = i_rd.a0;
            end else if (i_rd.v0 == rstep_pkg::SYS_EXIT) begin
                o_res.halt = 1'b1;
            end else if (i_rd.v0 == rstep_pkg::SYS_PRINT_CHAR) begin
                o_res.kind  = rstep_pkg::EV_PRINT_CHAR;
                o_res.value = {24'h000000, i_rd.a0[7:0]};
            end else begin
                o_res.kind  = rstep_pkg::EV_BAD_SYSCALL;
                o_res.value = i_rd.v0;
                o_res.halt  = 1'b1;
            end
        end

        // An invalid word keeps the index on itself.
        if (!w_legal) begin
            o_next_pc = i_pc;
        end else if (w_run && w_taken) begin
            o_next_pc = w_target;
        end else begin
            o_next_pc = w_inc;
        end
    end

endmodule

// ===== hw/rtl/risc_instruction_step_core.sv =====
// Flow: an input transfer is captured in the input register; then register read, execute
// and writeback go into the output register.
// Throughput: one instruction per cycle while the output is not stalled; the register
// file is read and written in the same execute cycle, so each instruction sees the
// previous one's result. Reset (synchronous, active low) clears all registers, the
// program index and the halt flag and empties both stages; no clearing pass is needed.
module risc_instruction_step_core #(
    parameter int PROG_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_instr_word,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [9:0]         o_next_index,
    output logic [2:0]         o_event_kind,
    output logic signed [31:0] o_event_value,
    output logic               o_is_halted
);

    localparam int IW    = $clog2(PROG_DEPTH);
    localparam int OFF_W = 17;

    logic                      w_in_full;
    logic                      w_load;
    logic                      w_advance;
    logic                      w_out_free;
    rstep_pkg::t_word          w_instr;
    logic [OFF_W-1:0]          w_biased;
    logic [OFF_W-1:0]          w_quot;
    rstep_pkg::t_reg_reads     w_rd;
    rstep_pkg::t_reg_write     w_wr;
    rstep_pkg::t_exec_result   w_res;
    logic [IW-1:0]             w_next_pc;
    logic [31:0]               w_next_ext;

    logic                      r_halt;
    logic                      n_halt;
    logic [IW-1:0]             r_pc;
    logic [IW-1:0]             n_pc;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [9:0]                r_out_index;
    rstep_pkg::t_event         r_out_kind;
    rstep_pkg::t_word          r_out_value;
    logic                      r_out_halt;

    // The output register frees up when it is empty or its result transfers now.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = w_in_full && w_out_free;
    assign o_stall    = w_in_full && !w_out_free;
    assign w_load     = i_valid && !o_stall;

    rstep_in_stage #(
        .PROG_DEPTH (PROG_DEPTH),
        .OFF_W      (OFF_W)
    ) u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_advance    (w_advance),
        .i_instr_word (i_instr_word),
        .o_full       (w_in_full),
        .o_instr      (w_instr),
        .o_biased     (w_biased),
        .o_quot       (w_quot)
    );

    rstep_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr_a (w_instr[25:21]),
        .i_rd_addr_b (w_instr[20:16]),
        .i_wr        (w_wr),
        .o_rd        (w_rd)
    );

    rstep_exec #(
        .PROG_DEPTH (PROG_DEPTH),
        .OFF_W      (OFF_W),
        .IW         (IW)
    ) u_exec (
        .i_instr   (w_instr),
        .i_biased  (w_biased),
        .i_quot    (w_quot),
        .i_pc      (r_pc),
        .i_halted  (r_halt),
        .i_rd      (w_rd),
        .o_res     (w_res),
        .o_next_pc (w_next_pc)
    );

    always_comb begin
        w_wr       = w_res.wb;
        w_wr.wr_en = w_res.wb.wr_en && w_advance;
    end

    assign w_next_ext = 32'(w_next_pc);

    always_comb begin
        n_halt      = r_halt;
        n_pc        = r_pc;
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_halt      = w_res.halt;
            n_pc        = w_next_pc;
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halt      <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_halt      <= n_halt;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_index <= w_next_ext[9:0];
            r_out_kind  <= w_res.kind;
            r_out_value <= w_res.value;
            r_out_halt  <= w_res.halt;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_next_index  = r_out_index;
    assign o_event_kind  = r_out_kind;
    assign o_event_value = $signed(r_out_value);
    assign o_is_halted   = r_out_halt;

`ifndef NO_ASSERTIONS
    // Once halted, only reset clears the flag.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    // A halted core raises no syscall event.
    a_halted_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_halt) |=>
        (o_event_kind == 3'(rstep_pkg::EV_NONE) ||
         o_event_kind == 3'(rstep_pkg::EV_INVALID)))
        else $error("event reported while halted");

    // An invalid word leaves the program index and the register state alone.
    a_invalid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_res.kind == rstep_pkg::EV_INVALID) |->
        (!w_wr.wr_en && w_next_pc == r_pc && w_res.value == '0))
        else $error("invalid word changed state");

    // The stage that executes must be full whenever the register file is written.
    a_write_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.wr_en |-> (w_in_full && w_out_free))
        else $error("register write without an executing instruction");
`endif

endmodule
